FILE: src/sidq_pkg.sv
// shared types, constants and codes for the sorted insert/delete queue
package sidq_pkg;

   localparam int CAPACITY   = 16;
   localparam int KEY_WIDTH  = 32;
   localparam int IDX_WIDTH  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_WIDTH  = $clog2(CAPACITY + 1);
   localparam int POS_WIDTH  = 5;
   localparam int STAT_WIDTH = 2;

   typedef logic signed [KEY_WIDTH-1:0] key_type;
   typedef logic [IDX_WIDTH-1:0]        idx_type;
   typedef logic [CNT_WIDTH-1:0]        cnt_type;
   typedef logic [STAT_WIDTH-1:0]       stat_type;

   // opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   // status codes
   localparam stat_type ST_DONE      = 2'd0;
   localparam stat_type ST_NOT_FOUND = 2'd1;
   localparam stat_type ST_FULL      = 2'd2;

   // flags handed from one cell to the next one up the row
   typedef struct packed {
      logic mark;   // this cell sits at or above the insert slot
      logic hit;    // an equal key was seen at this cell or below
   } link_type;

endpackage

FILE: src/sidq_cell.sv
// one storage cell of the sorted row: holds one key and shifts with its neighbors
module sidq_cell (
   input  logic               clock,
   input  sidq_pkg::idx_type  index,
   input  sidq_pkg::cnt_type  count,
   input  logic               update,
   input  logic               opcode,
   input  sidq_pkg::key_type  req_key,
   input  sidq_pkg::key_type  left_key,
   input  sidq_pkg::link_type left_link,
   input  sidq_pkg::key_type  right_key,
   output sidq_pkg::key_type  key_out,
   output sidq_pkg::link_type link_out,
   output logic               first_hit
);

   sidq_pkg::key_type key_ff;
   sidq_pkg::key_type key_in;
   logic              occupied;
   logic              ge_key;
   logic              eq_key;
   logic              mark;
   logic              hit;

   // compare the held key against the transaction key
   assign occupied = sidq_pkg::CNT_WIDTH'(index) < count;
   assign ge_key   = occupied && (key_ff >= req_key);
   assign eq_key   = occupied && (key_ff == req_key);
   assign mark     = ge_key || !occupied;
   assign hit      = left_link.hit || eq_key;
   assign first_hit = eq_key && !left_link.hit;

   // next key: take the new key at the slot, shift up above it, shift down on delete
   always_comb begin
      key_in = key_ff;
      if (update) begin
         if (opcode == sidq_pkg::OP_INSERT) begin
            if (mark) begin
               key_in = left_link.mark ? left_key : req_key;
            end
         end else if (hit) begin
            key_in = right_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out       = key_ff;
   assign link_out.mark = mark;
   assign link_out.hit  = hit;

endmodule

FILE: src/sorted_insert_delete_queue.sv
// Sorted queue of up to sidq_pkg::CAPACITY signed keys held in a row of compare/shift cells.
// Every cell compares its key with the transaction key in the same cycle, so an insert or a
// delete is applied to every cell at once: one transaction is accepted per cycle while rsp_stall is low,
// with the result in the next cycle from the response register. The delete path is set by the
// first-match flag rippling through the chain of cells. Equal keys are inserted in front of
// those already held; a delete removes the lowest equal key and reports its 1-based position.
module sorted_insert_delete_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic signed [sidq_pkg::KEY_WIDTH-1:0] req_key,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sidq_pkg::POS_WIDTH-1:0]      rsp_position,
   output logic [sidq_pkg::STAT_WIDTH-1:0]     rsp_status,
   output logic [sidq_pkg::POS_WIDTH-1:0]      rsp_stored_count
);

   sidq_pkg::key_type  cell_key  [sidq_pkg::CAPACITY];
   sidq_pkg::link_type cell_link [sidq_pkg::CAPACITY];
   logic               cell_first [sidq_pkg::CAPACITY];

   sidq_pkg::cnt_type  count_ff;
   sidq_pkg::cnt_type  count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   sidq_pkg::cnt_type  position_ff;
   sidq_pkg::cnt_type  position_in;
   sidq_pkg::stat_type status_ff;
   sidq_pkg::stat_type status_in;

   logic               accept;
   logic               full;
   logic               found;
   logic               update;
   sidq_pkg::cnt_type  hit_pos;

   // handshake: hold off while a result waits to be taken
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = count_ff == sidq_pkg::CNT_WIDTH'(sidq_pkg::CAPACITY);
   assign found     = cell_link[sidq_pkg::CAPACITY-1].hit;
   assign update    = accept && !((req_opcode == sidq_pkg::OP_INSERT) && full);

   // row of cells
   for (genvar i = 0; i < sidq_pkg::CAPACITY; i++) begin : g_cell
      sidq_pkg::key_type  left_key;
      sidq_pkg::link_type left_link;
      sidq_pkg::key_type  right_key;

      if (i == 0) begin : g_first
         assign left_key  = req_key;
         assign left_link = '0;
      end else begin : g_mid
         assign left_key  = cell_key[i-1];
         assign left_link = cell_link[i-1];
      end

      if (i == sidq_pkg::CAPACITY - 1) begin : g_last
         assign right_key = cell_key[i];
      end else begin : g_inner
         assign right_key = cell_key[i+1];
      end

      sidq_cell u_cell (
         .clock     (clock),
         .index     (sidq_pkg::IDX_WIDTH'(i)),
         .count     (count_ff),
         .update    (update),
         .opcode    (req_opcode),
         .req_key   (req_key),
         .left_key  (left_key),
         .left_link (left_link),
         .right_key (right_key),
         .key_out   (cell_key[i]),
         .link_out  (cell_link[i]),
         .first_hit (cell_first[i])
      );
   end

   // 1-based position of the first equal key
   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < sidq_pkg::CAPACITY; i++) begin
         if (cell_first[i]) begin
            hit_pos = hit_pos | sidq_pkg::CNT_WIDTH'(i + 1);
         end
      end
   end

   // count and result for the accepted transaction
   always_comb begin
      count_in     = count_ff;
      position_in  = position_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
         position_in  = '0;
         if (req_opcode == sidq_pkg::OP_INSERT) begin
            if (full) begin
               status_in = sidq_pkg::ST_FULL;
            end else begin
               status_in = sidq_pkg::ST_DONE;
               count_in  = count_ff + 1'b1;
            end
         end else if (found) begin
            status_in   = sidq_pkg::ST_DONE;
            position_in = hit_pos;
            count_in    = count_ff - 1'b1;
         end else begin
            status_in = sidq_pkg::ST_NOT_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      position_ff <= position_in;
      status_ff   <= status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = sidq_pkg::POS_WIDTH'(position_ff);
   assign rsp_status       = status_ff;
   assign rsp_stored_count = sidq_pkg::POS_WIDTH'(count_ff);

   // count stays within the row
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sidq_pkg::CNT_WIDTH'(sidq_pkg::CAPACITY))
      else $error("stored count beyond capacity");

   // every accepted transaction leaves a result
   a_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction without result");

   // a successful insert grows the count by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == sidq_pkg::OP_INSERT) && !full)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the count");

   // failed transactions report no position
   a_fail_no_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != sidq_pkg::ST_DONE)) |-> (position_ff == '0))
      else $error("failed transaction with nonzero position");

endmodule
